FILE: src/stwkr_pkg.sv
// Types and constants shared by the keyed-removal stack.
// No dependencies; imported by stwkr_cell and stack_with_keyed_removal_unit.
package stwkr_pkg;

    localparam int KEY_W = 64;

    typedef logic [KEY_W-1:0] key_t;

    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;
    localparam logic [1:0] MODE_LIST   = 2'd3;

    localparam logic [2:0] STAT_PUSHED   = 3'd0;
    localparam logic [2:0] STAT_FULL     = 3'd1;
    localparam logic [2:0] STAT_REMOVED  = 3'd2;
    localparam logic [2:0] STAT_NOTFOUND = 3'd3;
    localparam logic [2:0] STAT_EMPTY    = 3'd4;
    localparam logic [2:0] STAT_FOUND    = 3'd5;
    localparam logic [2:0] STAT_LISTED   = 3'd6;

    typedef struct packed {
        logic [1:0] mode;
        key_t       key;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        key_t       entry_key;
        logic [3:0] count;
        logic       last;
    } out_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;   // shift away from top, new key enters cell 0
        logic rot;    // rotate toward top, tail cell takes the head
        logic drop;   // shift toward top, head entry is discarded
    } cell_ctl_t;

endpackage

FILE: src/stwkr_cell.sv
// One storage cell of the keyed-removal stack chain.
// Depends on stwkr_pkg for key_t and cell_ctl_t.
module stwkr_cell import stwkr_pkg::*; (
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  logic      tail,       // this cell holds the bottom entry
    input  key_t      left_key,   // neighbor nearer the top (or the pushed key)
    input  key_t      right_key,  // neighbor nearer the bottom
    input  key_t      head_key,   // cell 0, wraps into the tail on rotate
    output key_t      data
);

    key_t data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            data_reg <= left_key;
        end else if (ctl.rot) begin
            data_reg <= tail ? head_key : right_key;
        end else if (ctl.drop) begin
            data_reg <= right_key;
        end
    end

    assign data = data_reg;

endmodule

FILE: src/stack_with_keyed_removal_unit.sv
// Keyed-removal stack: a chain of DEPTH key cells with top-of-stack at cell 0.
// Depends on stwkr_pkg and stwkr_cell.
//
// Usage:
//   s_ channel takes one request {mode, key}; m_ channel returns result items
//   {status, entry_key, count, last}, with last set on the final item of a
//   request. A push is handled from idle: its result is registered and a new
//   request is taken the next cycle, so pushes stream at one per cycle while
//   m_ready is high. Remove, search and list rotate the chain through the head
//   comparator, one entry per cycle but pausing while a due result cannot be
//   loaded, over fill steps (fill = entries held) after the request is taken:
//   remove and search give their single result as the rotation ends, list
//   gives one item per step, and the next request is taken after the scan.
//   Requests on an empty stack, and full pushes, answer without a scan.
//   A request is taken only when the controller is idle and the result
//   register is free or being drained.
//   Reset (aresetn low, synchronous) empties the stack and drops any
//   pending result; cell contents are not cleared.
//   When m_ready is low the result register holds; a list pauses its
//   rotation until the receiver takes each entry.
module stack_with_keyed_removal_unit import stwkr_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   cnt_reg, cnt_next;
    logic                found_reg, found_next;
    logic [1:0]          mode_reg, mode_next;
    key_t                key_reg, key_next;
    logic                m_valid_reg, m_valid_next;
    out_t                m_data_reg, out_next;
    logic                load_out;
    logic                out_free;
    logic                in_fire;
    logic                adv;
    logic                match;
    cell_ctl_t           ctl;
    key_t                cell_data [DEPTH];
    logic [DEPTH-1:0]    tail_vec;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign in_fire  = s_valid && s_ready;
    assign match    = (cell_data[0] == key_reg);
    assign adv      = out_free || ((mode_reg != MODE_LIST) && (cnt_reg != FILL_W'(1)));

    // cell chain
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        key_t left_key;
        key_t right_key;

        assign tail_vec[j] = (fill_reg == FILL_W'(j + 1));

        if (j == 0) begin : g_head
            assign left_key = s_data.key;
        end else begin : g_mid
            assign left_key = cell_data[j-1];
        end

        if (j == DEPTH - 1) begin : g_end
            assign right_key = cell_data[0];
        end else begin : g_inner
            assign right_key = cell_data[j+1];
        end

        stwkr_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .tail      (tail_vec[j]),
            .left_key  (left_key),
            .right_key (right_key),
            .head_key  (cell_data[0]),
            .data      (cell_data[j])
        );
    end

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        mode_next  = mode_reg;
        key_next   = key_reg;
        ctl        = '0;
        load_out   = 1'b0;
        out_next   = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    out_next.last = 1'b1;
                    unique case (s_data.mode)
                        MODE_PUSH: begin
                            load_out = 1'b1;
                            if (fill_reg == FILL_W'(DEPTH)) begin
                                out_next.status = STAT_FULL;
                            end else begin
                                ctl.push        = 1'b1;
                                fill_next       = fill_reg + FILL_W'(1);
                                out_next.status = STAT_PUSHED;
                            end
                            out_next.count = 4'(fill_next);
                        end
                        MODE_REMOVE, MODE_SEARCH, MODE_LIST: begin
                            if (fill_reg == '0) begin
                                load_out        = 1'b1;
                                out_next.status = (s_data.mode == MODE_SEARCH) ?
                                                  STAT_NOTFOUND : STAT_EMPTY;
                                out_next.count  = 4'(fill_reg);
                            end else begin
                                state_next = S_SCAN;
                                cnt_next   = fill_reg;
                                found_next = 1'b0;
                                mode_next  = s_data.mode;
                                key_next   = s_data.key;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (adv) begin
                    // first match seen at the head during remove is dropped
                    if ((mode_reg == MODE_REMOVE) && !found_reg && match) begin
                        ctl.drop   = 1'b1;
                        fill_next  = fill_reg - FILL_W'(1);
                        found_next = 1'b1;
                    end else begin
                        ctl.rot = 1'b1;
                        if ((mode_reg == MODE_SEARCH) && match) begin
                            found_next = 1'b1;
                        end
                    end
                    cnt_next = cnt_reg - FILL_W'(1);

                    if (mode_reg == MODE_LIST) begin
                        load_out           = 1'b1;
                        out_next.status    = STAT_LISTED;
                        out_next.entry_key = cell_data[0];
                        out_next.count     = 4'(fill_reg);
                        out_next.last      = (cnt_reg == FILL_W'(1));
                    end else if (cnt_reg == FILL_W'(1)) begin
                        load_out       = 1'b1;
                        out_next.last  = 1'b1;
                        out_next.count = 4'(fill_next);
                        if (mode_reg == MODE_REMOVE) begin
                            out_next.status = found_next ? STAT_REMOVED : STAT_NOTFOUND;
                        end else begin
                            out_next.status = found_next ? STAT_FOUND : STAT_NOTFOUND;
                        end
                    end

                    if (cnt_reg == FILL_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        key_reg  <= key_next;
        if (load_out) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
